[design/positional_list_engine_macros.svh]
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define PLE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/ple_pkg.sv]
`timescale 1ns / 1ps

package ple_pkg;

    localparam int PLE_CAPACITY   = 256;
    localparam int PLE_DATA_WIDTH = 32;
    localparam int POS_W          = 10;

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_DELETE = 2'd1;
    localparam logic [1:0] MODE_GET    = 2'd2;
    localparam logic [1:0] MODE_LOCATE = 2'd3;

    localparam logic [1:0] STS_OK    = 2'd0;
    localparam logic [1:0] STS_RANGE = 2'd1;
    localparam logic [1:0] STS_FULL  = 2'd2;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]        mode;
        logic [POS_W-1:0]  position;
        logic signed [31:0] item_value;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [POS_W-1:0]   found_position;
        logic [POS_W-1:0]   list_length;
        logic               is_empty;
    } t_rsp;

    // shared control for the cell row
    typedef struct packed {
        logic [1:0]       op;
        logic [POS_W-1:0] sel;   // 0-based target for insert/delete
        logic [POS_W-1:0] last;  // 0-based index of last live entry
    } t_cell_ctrl;

endpackage

[design/positional_list_engine.sv]
`timescale 1ns / 1ps
// Insert, delete, out-of-range and full requests: result registered on the accepting edge.
// Get and locate on a non-empty list: the cell row rotates once through all live entries,
// the head cell is inspected each cycle, and the result is registered from the done state.
// One request in flight at a time; the next is taken once the result register is free.
// Reset (sync, active low) clears the length and control; entry contents stay unknown.

`include "positional_list_engine_macros.svh"

module positional_list_engine import ple_pkg::*; #(
    parameter int CAPACITY   = PLE_CAPACITY,
    parameter int DATA_WIDTH = PLE_DATA_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_req i_in_req,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_rsp o_out_rsp
);

    localparam int LEN_W = $clog2(CAPACITY + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]            r_state,     n_state;
    logic [LEN_W-1:0]      r_count,     n_count;
    logic [POS_W-1:0]      r_step,      n_step;
    logic [1:0]            r_mode,      n_mode;
    logic [POS_W-1:0]      r_pos,       n_pos;
    logic [DATA_WIDTH-1:0] r_key,       n_key;
    logic signed [31:0]    r_rd,        n_rd;
    logic [POS_W-1:0]      r_found,     n_found;
    logic                  r_out_valid, n_out_valid;
    t_rsp                  r_out,       n_out;

    t_cell_ctrl            w_ctrl;
    logic [DATA_WIDTH-1:0] w_cell [CAPACITY];
    logic [DATA_WIDTH-1:0] w_key;
    logic [63:0]           w_key_wide;
    logic [63:0]           w_head_wide;
    logic [POS_W:0]        w_pos_x;
    logic [POS_W:0]        w_cnt_x;
    logic                  w_acc;
    logic                  w_ins_ok;
    logic                  w_rng_ok;
    logic                  w_full;
    logic [POS_W-1:0]      w_cnt10;
    logic [LEN_W-1:0]      w_new_cnt;

    assign w_key_wide  = {32'd0, i_in_req.item_value};
    assign w_key       = w_key_wide[DATA_WIDTH-1:0];
    assign w_head_wide = 64'(w_cell[0]);

    assign o_in_ready = (r_state == ST_IDLE) && (!r_out_valid || i_out_ready);
    assign w_acc      = i_in_valid && o_in_ready;

    assign w_pos_x  = {1'b0, i_in_req.position};
    assign w_cnt_x  = (POS_W + 1)'(r_count);
    assign w_cnt10  = POS_W'(r_count);
    assign w_ins_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x + 1'b1);
    assign w_rng_ok = (w_pos_x != '0) && (w_pos_x <= w_cnt_x);
    assign w_full   = (r_count == LEN_W'(CAPACITY));

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_prev;
            logic [DATA_WIDTH-1:0] w_next;
            if (gi == 0) begin : g_first
                assign w_prev = w_cell[gi];
            end else begin : g_mid_p
                assign w_prev = w_cell[gi-1];
            end
            if (gi == CAPACITY - 1) begin : g_last
                assign w_next = w_cell[gi];
            end else begin : g_mid_n
                assign w_next = w_cell[gi+1];
            end
            ple_cell #(
                .DATA_WIDTH (DATA_WIDTH),
                .CELL_IDX   (gi)
            ) u_cell (
                .i_clk  (i_clk),
                .i_ctrl (w_ctrl),
                .i_key  (w_key),
                .i_prev (w_prev),
                .i_next (w_next),
                .i_head (w_cell[0]),
                .o_data (w_cell[gi])
            );
        end
    endgenerate

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_step      = r_step;
        n_mode      = r_mode;
        n_pos       = r_pos;
        n_key       = r_key;
        n_rd        = r_rd;
        n_found     = r_found;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_new_cnt   = r_count;
        w_ctrl.op   = OP_HOLD;
        w_ctrl.sel  = i_in_req.position - 1'b1;
        w_ctrl.last = w_cnt10 - 1'b1;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        n_out.status         = STS_OK;
        n_out.read_value     = '0;
        n_out.found_position = '0;

        case (r_state)
            ST_IDLE: begin
                if (w_acc) begin
                    case (i_in_req.mode)
                        MODE_INSERT: begin
                            if (!w_ins_ok) begin
                                n_out.status = STS_RANGE;
                            end else if (w_full) begin
                                n_out.status = STS_FULL;
                            end else begin
                                w_ctrl.op = OP_INS;
                                w_new_cnt = r_count + 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        MODE_DELETE: begin
                            if (!w_rng_ok) begin
                                n_out.status = STS_RANGE;
                            end else begin
                                w_ctrl.op = OP_DEL;
                                w_new_cnt = r_count - 1'b1;
                            end
                            n_out_valid = 1'b1;
                        end
                        MODE_GET: begin
                            if (!w_rng_ok) begin
                                n_out.status = STS_RANGE;
                                n_out_valid  = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_out_valid = 1'b1;
                            end else begin
                                n_state = ST_SCAN;
                            end
                        end
                    endcase
                    n_count              = w_new_cnt;
                    n_out.list_length    = POS_W'(w_new_cnt);
                    n_out.is_empty       = (w_new_cnt == '0);
                    n_step               = '0;
                    n_mode               = i_in_req.mode;
                    n_pos                = i_in_req.position;
                    n_key                = w_key;
                    n_rd                 = '0;
                    n_found              = '0;
                end else begin
                    n_out.status         = r_out.status;
                    n_out.read_value     = r_out.read_value;
                    n_out.found_position = r_out.found_position;
                end
            end
            ST_SCAN: begin
                w_ctrl.op = OP_ROT;
                if (r_mode == MODE_GET) begin
                    if (r_step == r_pos - 1'b1) begin
                        n_rd = w_head_wide[31:0];
                    end
                end else if ((w_cell[0] == r_key) && (r_found == '0)) begin
                    n_found = r_step + 1'b1;
                end
                if (r_step == w_cnt10 - 1'b1) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
                n_out.status         = r_out.status;
                n_out.read_value     = r_out.read_value;
                n_out.found_position = r_out.found_position;
            end
            ST_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid          = 1'b1;
                    n_out.status         = STS_OK;
                    n_out.read_value     = r_rd;
                    n_out.found_position = r_found;
                    n_out.list_length    = w_cnt10;
                    n_out.is_empty       = (r_count == '0);
                    n_state              = ST_IDLE;
                end else begin
                    n_out.status         = r_out.status;
                    n_out.read_value     = r_out.read_value;
                    n_out.found_position = r_out.found_position;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_step  <= n_step;
        r_mode  <= n_mode;
        r_pos   <= n_pos;
        r_key   <= n_key;
        r_rd    <= n_rd;
        r_found <= n_found;
        r_out   <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out;

    `PLE_ASSERT_IMP(a_count_bound, 1'b1, r_count <= LEN_W'(CAPACITY), "length above capacity")
    `PLE_ASSERT_IMP(a_scan_step, r_state == ST_SCAN, (r_step < w_cnt10) && (r_count != '0), "scan past live entries")
    `PLE_ASSERT_NXT(a_scan_count, r_state == ST_SCAN, r_count == $past(r_count), "length moved during scan")
    `PLE_ASSERT_NXT(a_ins_grow, w_acc && (i_in_req.mode == MODE_INSERT) && w_ins_ok && !w_full, r_count == $past(r_count) + 1'b1, "insert did not grow list")

endmodule

[design/ple_cell.sv]
`timescale 1ns / 1ps

module ple_cell import ple_pkg::*; #(
    parameter int DATA_WIDTH = PLE_DATA_WIDTH,
    parameter int CELL_IDX   = 0
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic [DATA_WIDTH-1:0] i_key,
    input  logic [DATA_WIDTH-1:0] i_prev,
    input  logic [DATA_WIDTH-1:0] i_next,
    input  logic [DATA_WIDTH-1:0] i_head,
    output logic [DATA_WIDTH-1:0] o_data
);

    localparam logic [POS_W-1:0] IDX = POS_W'(CELL_IDX);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            OP_INS: begin
                if (IDX > i_ctrl.sel) begin
                    n_data = i_prev;
                end else if (IDX == i_ctrl.sel) begin
                    n_data = i_key;
                end
            end
            OP_DEL: begin
                if (IDX >= i_ctrl.sel) begin
                    n_data = i_next;
                end
            end
            OP_ROT: begin
                if (IDX == i_ctrl.last) begin
                    n_data = i_head;
                end else begin
                    n_data = i_next;
                end
            end
            default: n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule
